// ===== design/diff_drive_odometry_top_macros.svh =====
// Assertion macros shared by the odometry block.
`ifndef DIFF_DRIVE_ODOMETRY_TOP_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define DDO_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DDO_ASSERT_NEVER(label, clk, rst, cond, msg) \
  `DDO_ASSERT(label, clk, rst, !(cond), msg)
`else
`define DDO_ASSERT(label, clk, rst, prop, msg)
`define DDO_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== design/ddo_pkg.sv =====
// Shared constants, types and tables of the odometry block.
package ddo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN = 30;
  localparam int ATAN_IDX_W = $clog2(ATAN_LEN);
  localparam int DIV_Q_W = 32;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_METERS_PER_TICK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_TRIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_BASE = 2'd2;

  localparam logic [31:0] RST_METERS_PER_TICK = 32'd686975;
  localparam logic [17:0] RST_LEFT_TRIM = 18'd65674;
  localparam logic [23:0] RST_INV_BASE = 24'd233785;

  localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [19:0] VEL_SCALE = 20'd1000000;

  typedef enum logic [3:0] {
    OP_TRIM, OP_LH, OP_LL, OP_RH, OP_RL, OP_ROT, OP_TL, OP_TH, OP_CX, OP_SY
  } mul_op_t;

  typedef struct packed {
    logic                  load;
    logic                  issue;
    mul_op_t               op;
    logic                  cordic_init;
    logic                  cordic_step;
    logic [ATAN_IDX_W-1:0] iter;
    logic                  div_start;
    logic                  commit;
  } ddo_cmd_t;

  typedef struct packed {
    logic div_busy;
  } ddo_status_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } ddo_cfg_wr_t;

  function automatic logic [31:0] atan_angle(input logic [ATAN_IDX_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== design/ddo_intf.sv =====
// Channel interfaces of the odometry block.
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_ticks;
  logic signed [15:0] right_ticks;
  logic        [15:0] period_us;
  logic               zero_request;
  modport source (output valid, left_ticks, right_ticks, period_us, zero_request,
                  input ready);
  modport sink (input valid, left_ticks, right_ticks, period_us, zero_request,
                output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] yaw_rate;
  modport source (output valid, pos_x, pos_y, heading, vel_x, vel_y, yaw_rate,
                  input ready);
  modport sink (input valid, pos_x, pos_y, heading, vel_x, vel_y, yaw_rate,
                output ready);
endinterface

interface ddo_cfg_if import ddo_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/ddo_ctrl.sv =====
// Sequencer that steps the datapath through one odometry update.
module ddo_ctrl import ddo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        out_ready,
  input  ddo_status_t status,
  output logic        in_ready,
  output logic        out_valid,
  output ddo_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_OP, S_W1, S_W2, S_CINIT, S_CITER, S_DGO, S_DWAIT, S_COMMIT
  } state_t;

  state_t                state;
  mul_op_t               op;
  logic [ATAN_IDX_W-1:0] iter;

  function automatic mul_op_t next_op(input mul_op_t o);
    mul_op_t n;
    unique case (o)
      OP_TRIM: n = OP_LH;
      OP_LH:   n = OP_LL;
      OP_LL:   n = OP_RH;
      OP_RH:   n = OP_RL;
      OP_RL:   n = OP_ROT;
      OP_ROT:  n = OP_TL;
      OP_TL:   n = OP_TH;
      OP_CX:   n = OP_SY;
      default: n = OP_TRIM;
    endcase
    return n;
  endfunction

  always_comb begin
    in_ready         = (state == S_IDLE);
    cmd.load         = (state == S_IDLE) && in_valid;
    cmd.issue        = (state == S_OP);
    cmd.op           = op;
    cmd.cordic_init  = (state == S_CINIT);
    cmd.cordic_step  = (state == S_CITER);
    cmd.iter         = iter;
    cmd.div_start    = (state == S_DGO);
    cmd.commit       = (state == S_COMMIT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_TRIM;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          op    <= OP_TRIM;
          state <= S_OP;
        end
        S_OP: state <= S_W1;
        S_W1: state <= S_W2;
        S_W2: begin
          if (op == OP_TH) begin
            state <= S_CINIT;
          end else if (op == OP_SY) begin
            state <= S_DGO;
          end else begin
            op    <= next_op(op);
            state <= S_OP;
          end
        end
        S_CINIT: begin
          iter  <= '0;
          state <= S_CITER;
        end
        S_CITER: begin
          if (iter == ATAN_IDX_W'(CORDIC_STEPS - 1)) begin
            op    <= OP_CX;
            state <= S_OP;
          end else begin
            iter <= iter + 1'b1;
          end
        end
        S_DGO: state <= S_DWAIT;
        S_DWAIT: if (!status.div_busy) begin
          state <= S_COMMIT;
        end
        S_COMMIT: if (!out_valid || out_ready) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/ddo_div.sv =====
// Radix-2 velocity divider: scales a signed step to per second and saturates.
module ddo_div import ddo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [43:0] value,
  input  logic        [15:0] period,
  output logic               busy,
  output logic signed [31:0] result
);

  typedef enum logic [2:0] {D_IDLE, D_SCALE, D_CHECK, D_RUN, D_FIN} state_t;

  state_t               state;
  logic [43:0]          mag;
  logic                 neg;
  logic [15:0]          per;
  logic [63:0]          dvd;
  logic                 ovf;
  logic [15:0]          rem;
  logic [DIV_Q_W-1:0]   quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic [16:0]          rem2;
  logic                 ge;
  logic                 ovf_now;

  assign busy    = (state != D_IDLE);
  assign ovf_now = dvd[63:32] >= {16'd0, per};
  assign rem2    = {rem, quo[DIV_Q_W-1]};
  assign ge      = rem2 >= {1'b0, per};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE: if (start) begin
          mag   <= value[43] ? 44'(-value) : 44'(value);
          neg   <= value[43];
          per   <= period;
          state <= D_SCALE;
        end
        D_SCALE: begin
          dvd   <= 64'(mag) * 64'(VEL_SCALE);
          state <= D_CHECK;
        end
        D_CHECK: begin
          ovf   <= ovf_now;
          rem   <= dvd[47:32];
          quo   <= dvd[31:0];
          cnt   <= '0;
          state <= ovf_now ? D_FIN : D_RUN;
        end
        D_RUN: begin
          rem <= ge ? 16'(rem2 - {1'b0, per}) : rem2[15:0];
          quo <= {quo[DIV_Q_W-2:0], ge};
          if (cnt == DIV_CNT_W'(DIV_Q_W - 1)) begin
            state <= D_FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        D_FIN: begin
          if (ovf) begin
            result <= neg ? 32'sh80000000 : 32'sh7FFFFFFF;
          end else if (neg) begin
            result <= (quo > 32'h80000000) ? 32'sh80000000 : signed'(32'(32'd0 - quo));
          end else begin
            result <= quo[31] ? 32'sh7FFFFFFF : signed'(quo);
          end
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== design/ddo_datapath.sv =====
// Odometry datapath: settings, shared multiplier, CORDIC, velocity dividers, pose and result registers.
module ddo_datapath import ddo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ddo_cmd_t           cmd,
  output ddo_status_t        status,
  input  ddo_cfg_wr_t        cfg_wr,
  input  logic signed [15:0] left_ticks,
  input  logic signed [15:0] right_ticks,
  input  logic        [15:0] period_us,
  input  logic               zero_request,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] heading,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] yaw_rate
);

  logic [31:0] mpt;
  logic [17:0] trim;
  logic [23:0] ibw;

  logic signed [15:0] lt_r;
  logic        [15:0] per_r;
  logic        [33:0] mag_l;
  logic               neg_l;
  logic        [31:0] mag_r;
  logic               neg_r;
  logic        [49:0] acc;
  logic signed [34:0] dl;
  logic signed [34:0] dr;
  logic signed [35:0] sum;
  logic signed [43:0] rad16;
  logic signed [50:0] rad24;
  logic        [56:0] ang;
  logic        [31:0] step;
  logic        [31:0] half;
  logic signed [35:0] dx;
  logic signed [35:0] dy;
  logic        [31:0] x_pos;
  logic        [31:0] y_pos;
  logic        [31:0] hdg;

  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [33:0] cz;
  logic               flip;

  logic signed [35:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [35:0] opa;
  logic signed [31:0] opb;
  mul_op_t            op1;
  mul_op_t            op2;
  logic               v1;
  logic               v2;
  logic signed [67:0] prod;

  logic        [50:0] wheel_sum;
  logic signed [34:0] wheel_m;
  logic signed [67:0] rnd16;
  logic signed [67:0] rnd8;
  logic signed [67:0] rnd28;
  logic        [56:0] th_full;
  logic signed [33:0] c_full;
  logic signed [33:0] s_full;
  logic signed [31:0] c28;
  logic signed [31:0] s28;
  logic        [31:0] cang;
  logic               cflip;
  logic signed [33:0] shx;
  logic signed [33:0] shy;
  logic signed [33:0] atan_v;
  logic        [15:0] rt_mag;
  logic        [31:0] x_next;
  logic        [31:0] y_next;
  logic        [31:0] h_next;
  logic        [2:0]  busy;
  logic signed [31:0] vx_q;
  logic signed [31:0] vy_q;
  logic signed [31:0] yr_q;

  assign status.div_busy = |busy;

  assign c_full = flip ? -cx : cx;
  assign s_full = flip ? -cy : cy;
  assign c28    = 32'(c_full >>> 2);
  assign s28    = 32'(s_full >>> 2);

  always_comb begin
    unique case (cmd.op)
      OP_TRIM: begin mul_a = 36'(lt_r); mul_b = signed'({14'd0, trim}); end
      OP_LH:   begin mul_a = signed'({2'd0, mag_l}); mul_b = signed'({16'd0, mpt[31:16]}); end
      OP_LL:   begin mul_a = signed'({2'd0, mag_l}); mul_b = signed'({16'd0, mpt[15:0]}); end
      OP_RH:   begin mul_a = signed'({4'd0, mag_r}); mul_b = signed'({16'd0, mpt[31:16]}); end
      OP_RL:   begin mul_a = signed'({4'd0, mag_r}); mul_b = signed'({16'd0, mpt[15:0]}); end
      OP_ROT:  begin mul_a = 36'(dl) - 36'(dr); mul_b = signed'({8'd0, ibw}); end
      OP_TL:   begin
        mul_a = signed'({10'd0, rad24[25:0]});
        mul_b = signed'({2'd0, TURN_PER_RAD});
      end
      OP_TH:   begin
        mul_a = 36'(signed'(rad24[50:26]));
        mul_b = signed'({2'd0, TURN_PER_RAD});
      end
      OP_CX:   begin mul_a = sum; mul_b = c28; end
      OP_SY:   begin mul_a = sum; mul_b = s28; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign wheel_sum = 51'(acc) + 51'(prod[49:16]) + 51'd32768;
  assign rnd16     = prod + 68'sd32768;
  assign rnd8      = prod + 68'sd128;
  assign rnd28     = prod + 68'sd268435456;
  assign th_full   = ang + {prod[30:0], 26'd0};

  always_comb begin
    wheel_m = signed'(wheel_sum[50:16]);
    if ((op2 == OP_LL) ? neg_l : neg_r) begin
      wheel_m = -signed'(wheel_sum[50:16]);
    end
  end

  assign cang   = hdg + half;
  assign cflip  = cang[31] ^ cang[30];
  assign shx    = cx >>> cmd.iter;
  assign shy    = cy >>> cmd.iter;
  assign atan_v = signed'({2'd0, atan_angle(cmd.iter)});
  assign rt_mag = right_ticks[15] ? 16'(-right_ticks) : 16'(right_ticks);

  assign x_next = x_pos + dx[31:0];
  assign y_next = y_pos + dy[31:0];
  assign h_next = hdg + step;

  always_ff @(posedge clk) begin
    if (rst) begin
      mpt  <= RST_METERS_PER_TICK;
      trim <= RST_LEFT_TRIM;
      ibw  <= RST_INV_BASE;
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.index)
        CFG_METERS_PER_TICK: mpt  <= cfg_wr.data;
        CFG_LEFT_TRIM:       trim <= cfg_wr.data[17:0];
        CFG_INV_BASE:        ibw  <= cfg_wr.data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      x_pos <= '0;
      y_pos <= '0;
      hdg   <= '0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      if (cmd.load && zero_request) begin
        x_pos <= '0;
        y_pos <= '0;
        hdg   <= '0;
      end else if (cmd.commit) begin
        x_pos <= x_next;
        y_pos <= y_next;
        hdg   <= h_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lt_r  <= left_ticks;
      per_r <= (period_us == 16'd0) ? 16'd1 : period_us;
      mag_r <= {rt_mag, 16'd0};
      neg_r <= right_ticks[15];
    end
    if (cmd.issue) begin
      opa <= mul_a;
      opb <= mul_b;
      op1 <= cmd.op;
    end
    if (v1) begin
      prod <= 68'(opa) * 68'(opb);
      op2  <= op1;
    end
    if (v2) begin
      unique case (op2)
        OP_TRIM: begin
          mag_l <= prod[67] ? 34'(-prod) : prod[33:0];
          neg_l <= prod[67];
        end
        OP_LH, OP_RH: acc <= prod[49:0];
        OP_LL: dl <= wheel_m;
        OP_RL: dr <= wheel_m;
        OP_ROT: begin
          rad16 <= rnd16[59:16];
          rad24 <= rnd8[58:8];
          sum   <= 36'(dl) + 36'(dr);
        end
        OP_TL: ang <= prod[56:0];
        OP_TH: begin
          step <= th_full[55:24];
          half <= th_full[56:25];
        end
        OP_CX: dx <= rnd28[64:29];
        OP_SY: dy <= rnd28[64:29];
        default: ;
      endcase
    end
    if (cmd.cordic_init) begin
      flip <= cflip;
      cx   <= CORDIC_GAIN;
      cy   <= '0;
      cz   <= 34'(signed'({cang[31] ^ cflip, cang[30:0]}));
    end else if (cmd.cordic_step) begin
      if (!cz[33]) begin
        cx <= cx - shy;
        cy <= cy + shx;
        cz <= cz - atan_v;
      end else begin
        cx <= cx + shy;
        cy <= cy - shx;
        cz <= cz + atan_v;
      end
    end
    if (cmd.commit) begin
      pos_x    <= signed'(x_next);
      pos_y    <= signed'(y_next);
      heading  <= signed'(h_next);
      vel_x    <= vx_q;
      vel_y    <= vy_q;
      yaw_rate <= yr_q;
    end
  end

  ddo_div u_div_x (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .value  (44'(dx)),
    .period (per_r),
    .busy   (busy[0]),
    .result (vx_q)
  );

  ddo_div u_div_y (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .value  (44'(dy)),
    .period (per_r),
    .busy   (busy[1]),
    .result (vy_q)
  );

  ddo_div u_div_yaw (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .value  (rad16),
    .period (per_r),
    .busy   (busy[2]),
    .result (yr_q)
  );

endmodule

// ===== design/diff_drive_odometry_top.sv =====
// Top level of the differential-drive odometry block.
// One request is handled at a time; the result is produced by the shared multiplier
// sequence, the CORDIC iterations and the 32-step velocity divider, and is held back
// while the previous result has not been taken.
// The next request is taken once the result sits in the output register.
// Synchronous reset clears the pose and restores the register defaults.
`include "diff_drive_odometry_top_macros.svh"
module diff_drive_odometry_top import ddo_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ddo_in_if.sink     wheel,
  ddo_out_if.source  pose,
  ddo_cfg_if.sink    cfg
);

  ddo_cmd_t    cmd;
  ddo_status_t status;
  ddo_cfg_wr_t cfg_wr;

  assign cfg.ready    = 1'b1;
  assign cfg_wr.we    = cfg.valid;
  assign cfg_wr.index = cfg.index;
  assign cfg_wr.data  = cfg.data;

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wheel.valid),
    .out_ready (pose.ready),
    .status    (status),
    .in_ready  (wheel.ready),
    .out_valid (pose.valid),
    .cmd       (cmd)
  );

  ddo_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_wr       (cfg_wr),
    .left_ticks   (wheel.left_ticks),
    .right_ticks  (wheel.right_ticks),
    .period_us    (wheel.period_us),
    .zero_request (wheel.zero_request),
    .pos_x        (pose.pos_x),
    .pos_y        (pose.pos_y),
    .heading      (pose.heading),
    .vel_x        (pose.vel_x),
    .vel_y        (pose.vel_y),
    .yaw_rate     (pose.yaw_rate)
  );

  `DDO_ASSERT(a_commit_slot, clk, rst, cmd.commit |-> (!pose.valid || pose.ready), "result overwritten")
  `DDO_ASSERT(a_div_start, clk, rst, cmd.div_start |=> status.div_busy, "divider did not start")
  `DDO_ASSERT_NEVER(a_div_overlap, clk, rst, status.div_busy && (cmd.issue || cmd.commit), "step during divide")
  `DDO_ASSERT(a_load_busy, clk, rst, cmd.load |=> !wheel.ready, "request taken while busy")

endmodule
